// ----- rtl/msp_pkg.sv -----
// Shared types, codes and byte constants for the MIDI stream parser.
package msp_pkg;

  // Result kinds
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd3;
  localparam logic [2:0] KIND_NOTE_OFF = 3'd4;
  localparam logic [2:0] KIND_BEND  = 3'd5;
  localparam logic [2:0] KIND_CC    = 3'd6;

  // Input commands
  localparam logic CMD_FEED  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Stream bytes
  localparam logic [7:0] BYTE_TICK     = 8'hF8;
  localparam logic [7:0] BYTE_START    = 8'hFA;
  localparam logic [7:0] BYTE_CONTINUE = 8'hFB;
  localparam logic [7:0] BYTE_STOP     = 8'hFC;
  localparam logic [7:0] BYTE_SYSEX    = 8'hF0;
  localparam logic [7:0] BYTE_EOX      = 8'hF7;

  // Status high nibbles
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_CC       = 4'hB;
  localparam logic [3:0] HI_PROGRAM  = 4'hC;
  localparam logic [3:0] HI_CHAN_PRS = 4'hD;
  localparam logic [3:0] HI_BEND     = 4'hE;

  // Register addresses (word index)
  localparam logic REG_EVENT_ENABLE = 1'b0;

  localparam int ENABLE_W = 7;

  typedef struct packed {
    logic [7:0] running_status;
    logic [6:0] held_first_data;
    logic       have_first_data;
    logic       inside_sysex;
  } parse_state_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  event_kind;
    logic [3:0]  channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [13:0] bend_value;
  } result_t;

endpackage

// ----- rtl/msp_decode.sv -----
// Combinational byte decode: next parser state and the result for one request.
module msp_decode (
  input  msp_pkg::parse_state_t       state,
  input  logic                        cmd,
  input  logic [7:0]                  stream_byte,
  input  logic [msp_pkg::ENABLE_W-1:0] event_enable,
  output msp_pkg::parse_state_t       state_next,
  output msp_pkg::result_t            result
);
  import msp_pkg::*;

  logic       fire;
  logic [3:0] hi;

  assign hi = state.running_status[7:4];

  always_comb begin
    state_next = state;
    fire       = 1'b0;
    result     = '0;
    if (cmd == CMD_CLEAR) begin
      state_next.running_status  = '0;
      state_next.have_first_data = 1'b0;
      state_next.inside_sysex    = 1'b0;
    end else if (stream_byte >= BYTE_TICK) begin
      // realtime: state untouched
      case (stream_byte)
        BYTE_TICK: begin
          fire = 1'b1;
          result.event_kind = KIND_TICK;
        end
        BYTE_START, BYTE_CONTINUE: begin
          fire = 1'b1;
          result.event_kind = KIND_START;
        end
        BYTE_STOP: begin
          fire = 1'b1;
          result.event_kind = KIND_STOP;
        end
        default: fire = 1'b0;
      endcase
    end else if (stream_byte[7]) begin
      if (stream_byte == BYTE_SYSEX) begin
        state_next.inside_sysex    = 1'b1;
        state_next.running_status  = '0;
        state_next.have_first_data = 1'b0;
      end else if (stream_byte == BYTE_EOX) begin
        state_next.inside_sysex = 1'b0;
      end else if (stream_byte >= BYTE_SYSEX) begin
        // system common cancels running status
        state_next.running_status  = '0;
        state_next.have_first_data = 1'b0;
      end else begin
        state_next.running_status  = stream_byte;
        state_next.have_first_data = 1'b0;
      end
    end else if (state.inside_sysex || state.running_status == '0) begin
      fire = 1'b0;
    end else if (hi == HI_PROGRAM || hi == HI_CHAN_PRS) begin
      fire = 1'b0;
    end else if (!state.have_first_data) begin
      state_next.held_first_data = stream_byte[6:0];
      state_next.have_first_data = 1'b1;
    end else begin
      state_next.have_first_data = 1'b0;
      result.channel = state.running_status[3:0];
      case (hi)
        HI_NOTE_ON: begin
          fire = 1'b1;
          result.first_data = state.held_first_data;
          if (stream_byte[6:0] == 7'd0) begin
            result.event_kind = KIND_NOTE_OFF;
          end else begin
            result.event_kind  = KIND_NOTE_ON;
            result.second_data = stream_byte[6:0];
          end
        end
        HI_NOTE_OFF: begin
          fire = 1'b1;
          result.event_kind = KIND_NOTE_OFF;
          result.first_data = state.held_first_data;
        end
        HI_BEND: begin
          fire = 1'b1;
          result.event_kind = KIND_BEND;
          result.bend_value = {stream_byte[6:0], state.held_first_data};
        end
        HI_CC: begin
          fire = 1'b1;
          result.event_kind  = KIND_CC;
          result.first_data  = state.held_first_data;
          result.second_data = stream_byte[6:0];
        end
        default: fire = 1'b0; // poly pressure
      endcase
    end
    result.valid = fire & event_enable[result.event_kind];
  end

endmodule

// ----- rtl/midi_stream_parser_unit.sv -----
// Top level of the MIDI 1.0 byte stream parser with running status.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  input    | in        | in_valid/in_stall  | cmd, stream_byte
//  result   | out       | out_valid/out_stall| event_kind, channel, first_data,
//           |           |                    | second_data, bend_value
//  config   | in/out    | APB psel/penable   | event_enable at byte address 0
//
// One request per cycle sustained while the result side does not stall. A request
// is held in the input register, is decoded against the parser state, and its
// result (if any) lands in the result register, which drives out_valid.
// The decode of one byte is the only logic between input and result registers.
// rst clears the parser state, event_enable and both valid flags; no sweep.
// A stall on a valid result holds the result register; a request in the input register
// then holds too and in_stall rises, so nothing is dropped.
module midi_stream_parser_unit (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  stream_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_kind,
  output logic [3:0]  channel,
  output logic [6:0]  first_data,
  output logic [6:0]  second_data,
  output logic [13:0] bend_value,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import msp_pkg::*;

  // configuration register
  logic [ENABLE_W-1:0] event_enable;

  // input register
  logic       req_valid;
  logic       req_cmd;
  logic [7:0] req_byte;

  // parser state
  parse_state_t state;
  parse_state_t state_next;

  // result register
  result_t result_next;
  result_t result;

  logic advance;   // input register may hand its request to the decode
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_EVENT_ENABLE);
  assign prdata = (paddr[2] == REG_EVENT_ENABLE) ?
                  {{(32-ENABLE_W){1'b0}}, event_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_enable <= '0;
    end else if (wr_en) begin
      event_enable <= pwdata[ENABLE_W-1:0];
    end
  end

  // The result register frees when empty or when its result is taken.
  assign advance  = !result.valid || !out_stall;
  assign in_stall = req_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_cmd  <= cmd;
      req_byte <= stream_byte;
    end
  end

  msp_decode u_decode (
    .state        (state),
    .cmd          (req_cmd),
    .stream_byte  (req_byte),
    .event_enable (event_enable),
    .state_next   (state_next),
    .result       (result_next)
  );

  // State moves once per request, whether or not a result comes of it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (req_valid && advance) begin
      state <= state_next;
    end
  end

  // Only the valid flag is reset; payload loads with a new result.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= req_valid && result_next.valid;
      if (req_valid && result_next.valid) begin
        result.event_kind  <= result_next.event_kind;
        result.channel     <= result_next.channel;
        result.first_data  <= result_next.first_data;
        result.second_data <= result_next.second_data;
        result.bend_value  <= result_next.bend_value;
      end
    end
  end

  assign out_valid   = result.valid;
  assign event_kind  = result.event_kind;
  assign channel     = result.channel;
  assign first_data  = result.first_data;
  assign second_data = result.second_data;
  assign bend_value  = result.bend_value;

endmodule

// ----- rtl/msp_checker.sv -----
// Port-level checker for the MIDI stream parser, bound to the top level.
module msp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  event_kind,
  input logic [3:0]  channel,
  input logic [6:0]  first_data,
  input logic [6:0]  second_data,
  input logic [13:0] bend_value
);
  import msp_pkg::*;

  // no result straight out of reset
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(channel)
      && $stable(first_data) && $stable(second_data) && $stable(bend_value))
    else $error("stalled result changed");

  a_realtime_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == KIND_TICK || event_kind == KIND_START ||
                  event_kind == KIND_STOP)
      |-> channel == 4'd0 && first_data == 7'd0 && second_data == 7'd0
          && bend_value == 14'd0)
    else $error("realtime result carries data");

  a_bend_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != KIND_BEND |-> bend_value == 14'd0)
    else $error("bend value on non-bend result");

  a_note_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == KIND_NOTE_OFF || event_kind == KIND_BEND)
      |-> second_data == 7'd0)
    else $error("second data on note off or bend");

endmodule

bind midi_stream_parser_unit msp_checker u_msp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .event_kind  (event_kind),
  .channel     (channel),
  .first_data  (first_data),
  .second_data (second_data),
  .bend_value  (bend_value)
);

// ----- test/tb_midi_stream_parser_unit.sv -----
// Self-checking testbench for the MIDI stream parser: predicted events versus DUT results.
module tb_midi_stream_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import msp_pkg::*;

  // Byte codes the package does not name
  localparam logic [7:0] BYTE_SONG_POS = 8'hF2;   // system common, cancels running status
  localparam logic [7:0] BYTE_RESET    = 8'hFF;   // realtime with no event
  localparam logic [3:0] HI_POLY_PRS   = 4'hA;
  localparam logic [7:0] NO_STATUS     = 8'h00;

  // event_enable is register 0, so byte address 0
  localparam logic [2:0] ADDR_EVENT_ENABLE = {REG_EVENT_ENABLE, 2'b00};

  localparam int PHASES         = 6;
  localparam int PHASE_REQUESTS = 245;
  localparam int DRAIN_CYCLES   = 8;     // covers the input and result registers with margin
  localparam int HOLD_OFF       = 300;   // long receiver stall to back up the input
  localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles, well above HOLD_OFF

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  chan;
    logic [6:0]  note;
    logic [6:0]  value;
    logic [13:0] bend;
  } midi_event_t;

  // Scoreboard: a running-status MIDI decoder of its own plus the queue of
  // events it expects, matched in order against what the DUT hands out.
  class event_scoreboard;
    logic [6:0]  enable_mask;
    logic [7:0]  status;
    logic [6:0]  first_byte;
    bit          first_held;
    bit          in_sysex;
    midi_event_t pending_events[$];
    int          errors;
    int          matched;
    int          kind_seen[7];

    function new();
      enable_mask = '0;
      status      = NO_STATUS;
      first_byte  = '0;
      first_held  = 0;
      in_sysex    = 0;
      errors      = 0;
      matched     = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void set_enable(logic [6:0] mask);
      enable_mask = mask;
    endfunction

    function void queue_event(logic [2:0] kind, logic [3:0] chan, logic [6:0] note,
                              logic [6:0] value, logic [13:0] bend);
      if (enable_mask[kind])
        pending_events.push_back('{kind, chan, note, value, bend});
    endfunction

    // Decode one accepted request and queue the event it yields, if any.
    function void take_request(logic c, logic [7:0] b);
      logic [3:0] hi;
      logic [3:0] chan;
      if (c == CMD_CLEAR) begin
        // held first data byte survives a clear on purpose
        status     = NO_STATUS;
        first_held = 0;
        in_sysex   = 0;
        return;
      end
      if (b >= BYTE_TICK) begin
        case (b)
          BYTE_TICK:                queue_event(KIND_TICK, 4'd0, 7'd0, 7'd0, 14'd0);
          BYTE_START, BYTE_CONTINUE: queue_event(KIND_START, 4'd0, 7'd0, 7'd0, 14'd0);
          BYTE_STOP:                queue_event(KIND_STOP, 4'd0, 7'd0, 7'd0, 14'd0);
          default: ;
        endcase
        return;
      end
      if (b[7]) begin
        if (b == BYTE_SYSEX) begin
          in_sysex   = 1;
          status     = NO_STATUS;
          first_held = 0;
        end else if (b == BYTE_EOX) begin
          in_sysex = 0;
        end else if (b > BYTE_SYSEX) begin
          status     = NO_STATUS;
          first_held = 0;
        end else begin
          // channel status sets running status even with sysex still open
          status     = b;
          first_held = 0;
        end
        return;
      end
      if (in_sysex || status == NO_STATUS)
        return;
      hi   = status[7:4];
      chan = status[3:0];
      if (hi == HI_PROGRAM || hi == HI_CHAN_PRS)
        return;
      if (!first_held) begin
        first_byte = b[6:0];
        first_held = 1;
        return;
      end
      first_held = 0;
      case (hi)
        HI_NOTE_ON: begin
          if (b[6:0] == 7'd0)
            queue_event(KIND_NOTE_OFF, chan, first_byte, 7'd0, 14'd0);
          else
            queue_event(KIND_NOTE_ON, chan, first_byte, b[6:0], 14'd0);
        end
        HI_NOTE_OFF: queue_event(KIND_NOTE_OFF, chan, first_byte, 7'd0, 14'd0);
        HI_BEND:     queue_event(KIND_BEND, chan, 7'd0, 7'd0, {b[6:0], first_byte});
        HI_CC:       queue_event(KIND_CC, chan, first_byte, b[6:0], 14'd0);
        default: ;   // poly pressure: consumed silently
      endcase
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_event(midi_event_t got);
      midi_event_t want;
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event, expected none, got kind %0d ch %0d data %0d/%0d bend %0d",
                 $time, got.kind, got.chan, got.note, got.value, got.bend);
        return;
      end
      want = pending_events.pop_front();
      if (got.kind  != want.kind)  report("event_kind", want.kind, got.kind);
      if (got.chan  != want.chan)  report("channel", want.chan, got.chan);
      if (got.note  != want.note)  report("first_data", want.note, got.note);
      if (got.value != want.value) report("second_data", want.value, got.value);
      if (got.bend  != want.bend)  report("bend_value", want.bend, got.bend);
      matched++;
      if (want.kind < 7) kind_seen[want.kind]++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        cmd;
  logic [7:0]  stream_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  event_kind;
  logic [3:0]  channel;
  logic [6:0]  first_data;
  logic [6:0]  second_data;
  logic [13:0] bend_value;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  event_scoreboard sb = new();

  int send_idle_pct = 0;   // chance per cycle that the sender offers nothing
  int stall_pct     = 0;   // chance per cycle that the receiver stalls
  int hold_request  = 0;   // set by the sequence to start a long receiver stall
  int requests_sent = 0;
  int clears_sent   = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;

  midi_stream_parser_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .stream_byte (stream_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_kind  (event_kind),
    .channel     (channel),
    .first_data  (first_data),
    .second_data (second_data),
    .bend_value  (bend_value),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Monitors: everything is sampled at the rising edge, all driving happens on
  // the falling edge, so no sample races a drive.
  // ---------------------------------------------------------------------------

  // Every accepted request goes through the predictor in acceptance order.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.take_request(cmd, stream_byte);
  end

  // Every accepted result is checked against the oldest expected event.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_event(midi_event_t'({event_kind, channel, first_data, second_data, bend_value}));
  end

  // Mirror register writes into the predictor at the edge that commits them.
  always @(posedge clk) begin
    if (!rst && psel && penable && pwrite && pready && paddr == ADDR_EVENT_ENABLE)
      sb.set_enable(pwdata[6:0]);
  end

  // Watchdog: too long without a request or a result moving means a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no traffic for %0d cycles, %0d events outstanding",
               $time, quiet_cycles, sb.pending_events.size());
      $display("tb_midi_stream_parser_unit failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls at the current rate, or a long hold-off on
  // request; the hold-off is counted here so the sender keeps going meanwhile.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task starts and ends just after a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one request, with random idle cycles in front of it, and hold it
  // steady until it is taken. Valid is not dropped afterwards, so back-to-back
  // requests see no bubble unless an idle cycle is drawn.
  task automatic send_request(input logic c, input logic [7:0] b);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid    <= 1'b0;
      cmd         <= 1'($urandom);          // payload is don't-care while idle
      stream_byte <= 8'($urandom);
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    stream_byte <= b;
    do begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end while (!taken);
    requests_sent++;
    if (c == CMD_CLEAR) clears_sent++;
  endtask

  // Write event_enable (setup then access), then read it back.
  task automatic write_event_enable(input logic [6:0] mask);
    logic [31:0] readback;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_EVENT_ENABLE;
    pwdata  <= {25'd0, mask};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== {25'd0, mask}) begin
      sb.errors++;
      $display("%0t: event_enable readback mismatch, expected %0d, got %0d",
               $time, mask, readback);
    end
    settings_used++;
  endtask

  // Let the block drain: all expected events out, then DRAIN_CYCLES more so a
  // request that yields no event is surely through the pipe.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_events.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [6:0] random_data();
    case ($urandom_range(7))
      0:       return 7'd0;
      1:       return 7'd127;
      default: return 7'($urandom);
    endcase
  endfunction

  // Short directed pass: realtime bytes, note on and its velocity-zero form,
  // bend maximum, channel status inside sysex, stray end of sysex, system
  // common cancelling running status, silent one-byte messages, poly pressure,
  // and a clear in the middle of a message.
  task automatic run_directed();
    logic [7:0] dir_bytes[$];
    dir_bytes = '{BYTE_TICK, BYTE_START, BYTE_CONTINUE, BYTE_STOP, BYTE_RESET,
                  {HI_NOTE_ON, 4'h0}, 8'h00, 8'h7F, 8'h7F, 8'h00,
                  {HI_BEND, 4'hF}, 8'h7F, 8'h7F,
                  BYTE_SYSEX, {HI_CC, 4'h3}, 8'h11, BYTE_EOX, 8'h22, 8'h33,
                  BYTE_EOX, BYTE_SONG_POS, 8'h44,
                  {HI_PROGRAM, 4'h1}, 8'h10,
                  {HI_POLY_PRS, 4'h3}, 8'h10, 8'h20,
                  {HI_NOTE_ON, 4'h5}, 8'h12};
    foreach (dir_bytes[i])
      send_request(CMD_FEED, dir_bytes[i]);
    // clear between the two data bytes: neither following byte may complete it
    send_request(CMD_CLEAR, 8'hA5);
    send_request(CMD_FEED, 8'h34);
    send_request(CMD_FEED, 8'h56);
  endtask

  // One random burst: mostly well-formed messages with random content,
  // sprinkled with realtime bytes, plus truncated messages, clears and noise.
  task automatic send_random_message();
    logic [8:0] seq[$];
    logic [3:0] hi;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      case ($urandom_range(4))
        0:       hi = HI_NOTE_OFF;
        1:       hi = HI_NOTE_ON;
        2:       hi = HI_CC;
        3:       hi = HI_BEND;
        default: hi = HI_POLY_PRS;
      endcase
      // sometimes lean on whatever running status is left over
      if ($urandom_range(9) >= 3)
        seq.push_back({CMD_FEED, hi, 4'($urandom_range(15))});
      repeat ($urandom_range(3, 1)) begin
        seq.push_back({CMD_FEED, 1'b0, random_data()});
        seq.push_back({CMD_FEED, 1'b0, random_data()});
      end
      if ($urandom_range(9) == 0)
        void'(seq.pop_back());              // message cut short
    end else if (pick < 63) begin
      hi = $urandom_range(1) ? HI_PROGRAM : HI_CHAN_PRS;
      seq.push_back({CMD_FEED, hi, 4'($urandom_range(15))});
      repeat ($urandom_range(3, 1))
        seq.push_back({CMD_FEED, 1'b0, random_data()});
    end else if (pick < 73) begin
      seq.push_back({CMD_FEED, BYTE_SYSEX});
      repeat ($urandom_range(4)) begin
        if ($urandom_range(4) == 0)
          seq.push_back({CMD_FEED,
                         8'($urandom_range({HI_BEND, 4'hF}, {HI_NOTE_OFF, 4'h0}))});
        else
          seq.push_back({CMD_FEED, 1'b0, random_data()});
      end
      if ($urandom_range(5) != 0)
        seq.push_back({CMD_FEED, BYTE_EOX});
    end else if (pick < 78) begin
      seq.push_back({CMD_FEED, 8'($urandom_range(BYTE_EOX - 1, BYTE_SYSEX + 1))});
      repeat ($urandom_range(2))
        seq.push_back({CMD_FEED, 1'b0, random_data()});
    end else if (pick < 83) begin
      seq.push_back({CMD_CLEAR, 8'($urandom)});
    end else if (pick < 88) begin
      if ($urandom_range(1))
        seq.push_back({CMD_FEED, BYTE_EOX});
      else
        seq.push_back({CMD_FEED, 1'b0, random_data()});
    end else begin
      seq.push_back({CMD_FEED, 8'($urandom)});
    end
    foreach (seq[i]) begin
      if ($urandom_range(99) < 8)
        send_request(CMD_FEED, 8'($urandom_range(BYTE_RESET, BYTE_TICK)));
      send_request(seq[i][8], seq[i][7:0]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed pass, then six random phases, each setting an
  // enable mask and idle pattern. Register writes only happen once drained.
  // ---------------------------------------------------------------------------
  initial begin
    int         phase_start;
    logic [6:0] mask;
    rst         = 1'b1;
    in_valid    = 1'b0;
    cmd         = CMD_FEED;
    stream_byte = 8'h00;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = ADDR_EVENT_ENABLE;
    pwdata      = 32'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_event_enable(7'h7F);
    run_directed();
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin mask = 7'h7F;               send_idle_pct = 0;  stall_pct = 0;  end
        1: begin mask = 7'($urandom);         send_idle_pct = 76; stall_pct = 0;  end
        2: begin mask = 7'h7F;               send_idle_pct = 0;  stall_pct = 76; end
        3: begin mask = 7'h00;               send_idle_pct = 11; stall_pct = 11; end
        4: begin mask = 7'h7F;               send_idle_pct = 0;  stall_pct = 0;  end
        default: begin mask = 7'($urandom);   send_idle_pct = 11; stall_pct = 11; end
      endcase
      write_event_enable(mask);
      // back-pressure phase: receiver holds off while the sender streams
      if (phase == 4)
        hold_request = HOLD_OFF;
      phase_start = requests_sent;
      while (requests_sent - phase_start < PHASE_REQUESTS)
        send_random_message();
      settle();
    end

    $display("summary: %0d requests (%0d clears) over %0d enable settings and four idle patterns",
             requests_sent, clears_sent, settings_used);
    $display("summary: %0d events matched: tick %0d, start %0d, stop %0d, on %0d, off %0d, bend %0d, cc %0d",
             sb.matched, sb.kind_seen[KIND_TICK], sb.kind_seen[KIND_START],
             sb.kind_seen[KIND_STOP], sb.kind_seen[KIND_NOTE_ON], sb.kind_seen[KIND_NOTE_OFF],
             sb.kind_seen[KIND_BEND], sb.kind_seen[KIND_CC]);
    if (sb.errors == 0)
      $display("tb_midi_stream_parser_unit passed");
    else
      $display("tb_midi_stream_parser_unit failed");
    $finish;
  end

endmodule
